// ----- src/srch_pkg.sv -----
// ----------------------------------------------------------------------------
// srch_pkg
// Shared types and constants for the sorted run count histogram core.
// ----------------------------------------------------------------------------
package srch_pkg;

    // Fixed field widths
    localparam int FUNC_W = 2;
    localparam int IDX_W  = 8;
    localparam int DIST_W = 32;
    localparam int BIN_W  = 40;

    // Result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    // Input item function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_KEY   = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    // Result item kinds
    typedef enum logic {
        KIND_DISTINCT = 1'b0,
        KIND_BIN      = 1'b1
    } kind_t;

    // One result transaction
    typedef struct packed {
        kind_t              kind;
        logic [DIST_W-1:0]  distinct;
        logic [BIN_W-1:0]   bin;
    } result_t;

    // Run tracker status toward the top level
    typedef struct packed {
        logic inc0_valid;
        logic inc1_valid;
        logic done;
    } trk_stat_t;

    // Histogram unit control
    typedef struct packed {
        logic inc0_valid;
        logic inc1_valid;
        logic clear;
    } hist_ctl_t;

endpackage

// ----- src/srch_run_tracker.sv -----
// ----------------------------------------------------------------------------
// srch_run_tracker
// Tracks the open run and batch over the key stream; emits the bins of the
// runs that close on each key and the distinct count when a batch ends.
// ----------------------------------------------------------------------------
module srch_run_tracker
    import srch_pkg::*;
#(
    parameter int LENGTH_CAP = 255,
    parameter int KEY_BITS   = 42,
    parameter int LEN_W      = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                key_valid,
    input  logic [KEY_BITS-1:0] key,
    input  logic                last,
    output trk_stat_t           stat,
    output logic [LEN_W-1:0]    inc0_bin,
    output logic [LEN_W-1:0]    inc1_bin,
    output logic [DIST_W-1:0]   distinct
);

    localparam logic [LEN_W-1:0] CAP = LEN_W'(LENGTH_CAP);

    logic [KEY_BITS-1:0] prev_key_reg, prev_key_next;
    logic [LEN_W-1:0]    run_len_reg, run_len_next;
    logic                in_batch_reg, in_batch_next;
    logic [DIST_W-1:0]   dist_reg, dist_next;

    logic [LEN_W-1:0]    mid_len;
    logic [DIST_W-1:0]   mid_dist;
    logic                close_a;
    logic                close_b;

    // Run and batch update for one key
    always_comb
    begin
        prev_key_next = prev_key_reg;
        mid_len       = run_len_reg;
        mid_dist      = dist_reg;
        in_batch_next = in_batch_reg;
        close_a       = 1'b0;
        close_b       = 1'b0;
        if (key_valid)
        begin
            if (!in_batch_reg)
            begin
                in_batch_next = 1'b1;
                mid_dist      = '0;
                prev_key_next = key;
                mid_len       = LEN_W'(1);
            end
            else if (key == prev_key_reg)
            begin
                if (run_len_reg < CAP)
                begin
                    mid_len = run_len_reg + LEN_W'(1);
                end
            end
            else
            begin
                close_a       = 1'b1;
                mid_dist      = (dist_reg == '1) ? dist_reg : dist_reg + DIST_W'(1);
                prev_key_next = key;
                mid_len       = LEN_W'(1);
            end
            close_b = last;
        end
        // batch end closes the final run
        distinct     = (mid_dist == '1) ? mid_dist : mid_dist + DIST_W'(1);
        run_len_next = mid_len;
        dist_next    = mid_dist;
        if (close_b)
        begin
            in_batch_next = 1'b0;
            run_len_next  = '0;
            dist_next     = '0;
        end
    end

    // Closed runs, first one in inc0
    assign stat.inc0_valid = close_a | close_b;
    assign stat.inc1_valid = close_a & close_b;
    assign stat.done       = close_b;
    assign inc0_bin        = close_a ? run_len_reg : mid_len;
    assign inc1_bin        = mid_len;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_key_reg <= '0;
            run_len_reg  <= '0;
            in_batch_reg <= 1'b0;
            dist_reg     <= '0;
        end
        else
        begin
            prev_key_reg <= prev_key_next;
            run_len_reg  <= run_len_next;
            in_batch_reg <= in_batch_next;
            dist_reg     <= dist_next;
        end
    end

endmodule

// ----- src/srch_hist_mem.sv -----
// ----------------------------------------------------------------------------
// srch_hist_mem
// Histogram bin memory with a one-per-cycle saturating read-modify-write,
// a one-entry pending slot for a second increment, and a forwarded read port.
// ----------------------------------------------------------------------------
module srch_hist_mem
    import srch_pkg::*;
#(
    parameter int NUM_BINS = 256,
    parameter int BIN_AW   = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  hist_ctl_t         ctl,
    input  logic [BIN_AW-1:0] inc0_bin,
    input  logic [BIN_AW-1:0] inc1_bin,
    input  logic [BIN_AW-1:0] rd_bin,
    output logic [BIN_W-1:0]  rd_value
);

    logic [BIN_W-1:0]    hist_mem [NUM_BINS];
    logic [NUM_BINS-1:0] vld_reg;

    logic                pend_valid_reg, pend_valid_next;
    logic [BIN_AW-1:0]   pend_bin_reg, pend_bin_next;
    logic                rmw_valid_reg;
    logic [BIN_AW-1:0]   rmw_bin_reg;
    logic [BIN_W-1:0]    rmw_data_reg;
    logic                rmw_vld_reg;
    logic                lw_valid_reg;
    logic [BIN_AW-1:0]   lw_bin_reg;
    logic [BIN_W-1:0]    lw_data_reg;
    logic [BIN_AW-1:0]   rd_bin_reg;
    logic [BIN_W-1:0]    rd_data_reg;
    logic                rd_vld_reg;

    logic                issue_valid;
    logic [BIN_AW-1:0]   issue_bin;
    logic [BIN_W-1:0]    cur_value;
    logic [BIN_W-1:0]    upd_value;
    logic                wr_en;

    // Issue select: pending slot first, overflow goes to the slot
    always_comb
    begin
        issue_valid     = 1'b0;
        issue_bin       = inc0_bin;
        pend_valid_next = 1'b0;
        pend_bin_next   = inc1_bin;
        if (ctl.clear)
        begin
            issue_valid = 1'b0;
        end
        else if (pend_valid_reg)
        begin
            issue_valid     = 1'b1;
            issue_bin       = pend_bin_reg;
            pend_valid_next = ctl.inc0_valid;
            pend_bin_next   = inc0_bin;
        end
        else
        begin
            issue_valid     = ctl.inc0_valid;
            issue_bin       = inc0_bin;
            pend_valid_next = ctl.inc1_valid;
            pend_bin_next   = inc1_bin;
        end
    end

    // Modify: forward the previous write, then saturating increment
    always_comb
    begin
        if (lw_valid_reg && (lw_bin_reg == rmw_bin_reg))
        begin
            cur_value = lw_data_reg;
        end
        else
        begin
            cur_value = rmw_vld_reg ? rmw_data_reg : '0;
        end
        upd_value = (cur_value == '1) ? cur_value : cur_value + BIN_W'(1);
    end

    // A clear drops the write in flight
    assign wr_en = rmw_valid_reg & ~ctl.clear;

    // Read port: in-flight update, then last write, then memory
    always_comb
    begin
        if (rmw_valid_reg && (rmw_bin_reg == rd_bin_reg))
        begin
            rd_value = upd_value;
        end
        else if (lw_valid_reg && (lw_bin_reg == rd_bin_reg))
        begin
            rd_value = lw_data_reg;
        end
        else
        begin
            rd_value = rd_vld_reg ? rd_data_reg : '0;
        end
    end

    // Memory array and payload registers
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[rmw_bin_reg] <= upd_value;
        end
        rmw_data_reg <= hist_mem[issue_bin];
        rd_data_reg  <= hist_mem[rd_bin];
        rmw_bin_reg  <= issue_bin;
        rd_bin_reg   <= rd_bin;
        pend_bin_reg <= pend_bin_next;
        lw_bin_reg   <= rmw_bin_reg;
        lw_data_reg  <= upd_value;
    end

    // Valid bits and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            pend_valid_reg <= 1'b0;
            rmw_valid_reg  <= 1'b0;
            rmw_vld_reg    <= 1'b0;
            lw_valid_reg   <= 1'b0;
            rd_vld_reg     <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                vld_reg <= '0;
            end
            else if (wr_en)
            begin
                vld_reg[rmw_bin_reg] <= 1'b1;
            end
            pend_valid_reg <= pend_valid_next;
            rmw_valid_reg  <= issue_valid;
            rmw_vld_reg    <= vld_reg[issue_bin];
            lw_valid_reg   <= wr_en;
            rd_vld_reg     <= vld_reg[rd_bin];
        end
    end

`ifndef SYNTHESIS
    // Pending slot is never asked to hold two increments
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> !ctl.inc1_valid)
        else $error("hist: pending slot overrun");

    // A clear leaves nothing in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> (!rmw_valid_reg && !lw_valid_reg && !pend_valid_reg))
        else $error("hist: update survived a clear");

    // Clear items carry no increment
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |-> (!ctl.inc0_valid && !ctl.inc1_valid))
        else $error("hist: increment with clear");
`endif

endmodule

// ----- src/srch_result_fifo.sv -----
// ----------------------------------------------------------------------------
// srch_result_fifo
// Small result queue that decouples the pipeline from the output stall.
// ----------------------------------------------------------------------------
module srch_result_fifo
    import srch_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  result_t            push_data,
    input  logic               out_stall,
    output logic               out_valid,
    output result_t            head,
    output logic [FIFO_CW-1:0] count
);

    result_t              entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg, count_next;
    logic                 pop;

    assign out_valid  = (count_reg != '0);
    assign pop        = out_valid & ~out_stall;
    assign head       = entry_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign count_next = count_reg + FIFO_CW'(push) - FIFO_CW'(pop);

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    // Upstream credit check keeps the queue from overflowing
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (count_reg != FIFO_CW'(FIFO_DEPTH)))
        else $error("fifo: push into full queue");
`endif

endmodule

// ----- src/sorted_run_count_histogram_core.sv -----
// ----------------------------------------------------------------------------
// sorted_run_count_histogram_core
// Run-length histogram over a stream of sorted keys.
//
// One transaction is accepted per cycle, every cycle, while in_stall is low.
// Key items update the open run; a run that closes adds one to the bin equal
// to its length (LENGTH_CAP and longer go to bin LENGTH_CAP), and the key
// marked last ends the batch with a distinct-count result. Read items return
// one bin, clear items zero the whole histogram at once (per-bin valid bits,
// no clearing pass). A result passes the input register and the result stage
// into the result queue, which drives out_valid. The bin memory takes one
// read-modify-write each cycle; a key that closes two runs parks the second
// increment in a one-entry slot that drains next cycle unless a clear drops
// it. in_stall rises once results in flight would fill the four-entry queue.
// ----------------------------------------------------------------------------
module sorted_run_count_histogram_core
    import srch_pkg::*;
#(
    parameter int LENGTH_CAP = 255,
    parameter int KEY_BITS   = 42
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [FUNC_W-1:0]   func,
    input  logic [KEY_BITS-1:0] key,
    input  logic                last_key,
    input  logic [IDX_W-1:0]    bin_index,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                result_kind,
    output logic [DIST_W-1:0]   distinct_count,
    output logic [BIN_W-1:0]    bin_value
);

    localparam int NUM_BINS = LENGTH_CAP + 1;
    localparam int BIN_AW   = $clog2(NUM_BINS);
    localparam int WIDE_W   = BIN_AW + IDX_W;
    localparam int OCC_W    = FIFO_CW + 1;

    logic                accept;

    logic                s1_valid_reg;
    logic [FUNC_W-1:0]   s1_func_reg;
    logic [KEY_BITS-1:0] s1_key_reg;
    logic                s1_last_reg;
    logic [IDX_W-1:0]    s1_idx_reg;

    logic                s1_is_key;
    logic                s1_is_read;
    logic                s1_is_clear;
    logic                s1_has_result;
    logic [WIDE_W-1:0]   s1_idx_wide;
    logic [BIN_AW-1:0]   s1_rd_addr;
    logic                s1_rd_ok;

    trk_stat_t           trk_stat;
    logic [BIN_AW-1:0]   trk_inc0_bin;
    logic [BIN_AW-1:0]   trk_inc1_bin;
    logic [DIST_W-1:0]   trk_distinct;

    hist_ctl_t           hist_ctl;
    logic [BIN_W-1:0]    hist_rd_value;

    logic                s2_valid_reg;
    kind_t               s2_kind_reg;
    logic [DIST_W-1:0]   s2_distinct_reg;
    logic                s2_rd_ok_reg;

    result_t             push_data;
    result_t             head;
    logic [FIFO_CW-1:0]  fifo_count;
    logic [OCC_W-1:0]    occupancy;

    // Input handshake: stall on registered state only, queue fill plus results in flight
    assign occupancy = OCC_W'(fifo_count) + OCC_W'(s1_has_result) + OCC_W'(s2_valid_reg);
    assign in_stall  = (occupancy >= OCC_W'(FIFO_DEPTH));
    assign accept    = in_valid & ~in_stall;

    // Input register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg <= func;
            s1_key_reg  <= key;
            s1_last_reg <= last_key;
            s1_idx_reg  <= bin_index;
        end
    end

    // Function decode
    always_comb
    begin
        s1_is_key   = 1'b0;
        s1_is_read  = 1'b0;
        s1_is_clear = 1'b0;
        unique case (s1_func_reg)
            FUNC_KEY:   s1_is_key   = s1_valid_reg;
            FUNC_READ:  s1_is_read  = s1_valid_reg;
            FUNC_CLEAR: s1_is_clear = s1_valid_reg;
            default:    ;
        endcase
    end

    // Read address and range check
    assign s1_idx_wide   = {{BIN_AW{1'b0}}, s1_idx_reg};
    assign s1_rd_addr    = s1_idx_wide[BIN_AW-1:0];
    assign s1_rd_ok      = (s1_idx_wide < WIDE_W'(NUM_BINS));
    assign s1_has_result = s1_is_read | trk_stat.done;

    srch_run_tracker #(
        .LENGTH_CAP (LENGTH_CAP),
        .KEY_BITS   (KEY_BITS),
        .LEN_W      (BIN_AW)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (s1_is_key),
        .key       (s1_key_reg),
        .last      (s1_last_reg),
        .stat      (trk_stat),
        .inc0_bin  (trk_inc0_bin),
        .inc1_bin  (trk_inc1_bin),
        .distinct  (trk_distinct)
    );

    assign hist_ctl.inc0_valid = trk_stat.inc0_valid;
    assign hist_ctl.inc1_valid = trk_stat.inc1_valid;
    assign hist_ctl.clear      = s1_is_clear;

    srch_hist_mem #(
        .NUM_BINS (NUM_BINS),
        .BIN_AW   (BIN_AW)
    ) u_hist (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (hist_ctl),
        .inc0_bin (trk_inc0_bin),
        .inc1_bin (trk_inc1_bin),
        .rd_bin   (s1_rd_addr),
        .rd_value (hist_rd_value)
    );

    // Result stage payload
    always_ff @(posedge clk)
    begin
        s2_kind_reg     <= s1_is_read ? KIND_BIN : KIND_DISTINCT;
        s2_distinct_reg <= s1_is_read ? '0 : trk_distinct;
        s2_rd_ok_reg    <= s1_rd_ok;
    end

    // Pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_has_result;
        end
    end

    // Assemble the result transaction
    assign push_data.kind     = s2_kind_reg;
    assign push_data.distinct = s2_distinct_reg;
    assign push_data.bin      = ((s2_kind_reg == KIND_BIN) && s2_rd_ok_reg)
                                ? hist_rd_value : '0;

    srch_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid_reg),
        .push_data (push_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .head      (head),
        .count     (fifo_count)
    );

    assign result_kind    = head.kind;
    assign distinct_count = head.distinct;
    assign bin_value      = head.bin;

endmodule
